// ===== rtl/sea_pkg.sv =====
// Shared types, type codes and helper functions for the saturating element-wise ALU.
package sea_pkg;

  localparam int unsigned NumCells = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_OPERATION = 2'd0,
    REG_SOURCE    = 2'd1,
    REG_DEST      = 2'd2
  } reg_idx_e;

  // Type codes: 0 u8, 1 s8, 2 u16, 3 s16, 4 u32, 5 s32; 6 and 7 act as s32.
  typedef logic [2:0] type_code_t;

  // Data carried from cell to cell down the chain.
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        neg;
    logic [63:0] mag;
    logic [31:0] den;
    logic [32:0] rem;
  } cell_data_t;

  function automatic logic [5:0] type_width(input type_code_t t);
    logic [5:0] w;
    if (t[2]) begin
      w = 6'd32;
    end else if (t[1]) begin
      w = 6'd16;
    end else begin
      w = 6'd8;
    end
    return w;
  endfunction

  function automatic logic type_signed(input type_code_t t);
    return t[0] | (t[2] & t[1]);
  endfunction

endpackage

// ===== rtl/sea_if.sv =====
// Stream and configuration interfaces of the saturating element-wise ALU.
interface sea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_bits;
  logic [31:0] right_bits;
  modport source (output valid, output left_bits, output right_bits, input ready);
  modport sink (input valid, input left_bits, input right_bits, output ready);
endinterface

interface sea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source (output valid, output result_bits, input ready);
  modport sink (input valid, input result_bits, output ready);
endinterface

interface sea_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/saturating_elementwise_alu_core.sv =====
// Top level of the saturating element-wise add, subtract, multiply and divide unit.
// One transaction on the input channel carries a pair of source elements and
// yields exactly one saturated destination element on the output channel,
// in order. A new transaction is taken in every cycle in which the output
// register is empty or is being emptied, so the sustained rate is one item
// per clock. The pipeline is one front stage that decodes operands and
// forms sums and products, a chain of 32 division cells that each resolve one
// quotient bit (other operations ride through unchanged), and the output
// register, which takes the value saturated to the destination type. The whole
// chain advances together and holds while the output is stalled. Configuration
// writes are always accepted and should only be made while no transaction is
// in flight.
module saturating_elementwise_alu_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  sea_cfg_if.sink      cfg_i,
  sea_in_if.sink       in_i,
  sea_out_if.source    out_o
);

  sea_pkg::op_e        op_q;
  sea_pkg::type_code_t src_q, dst_q;
  logic                advance;
  sea_pkg::cell_data_t chain [sea_pkg::NumCells + 1];

  assign cfg_i.ready = 1'b1;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= sea_pkg::OP_ADD;
      src_q <= '0;
      dst_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sea_pkg::REG_OPERATION: op_q  <= sea_pkg::op_e'(cfg_i.data[1:0]);
        sea_pkg::REG_SOURCE:    src_q <= cfg_i.data[2:0];
        sea_pkg::REG_DEST:      dst_q <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register can take a new value.
  assign advance    = !out_o.valid || out_o.ready;
  assign in_i.ready = advance;

  sea_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_i.valid),
    .left_i  (in_i.left_bits),
    .right_i (in_i.right_bits),
    .op_i    (op_q),
    .src_i   (src_q),
    .data_o  (chain[0])
  );

  for (genvar i = 0; i < sea_pkg::NumCells; i++) begin : g_cell
    sea_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .data_i (chain[i]),
      .data_o (chain[i + 1])
    );
  end

  sea_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .data_i   (chain[sea_pkg::NumCells]),
    .dst_i    (dst_q),
    .valid_o  (out_o.valid),
    .result_o (out_o.result_bits)
  );

  // A stalled chain must not lose or create transactions.
  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(chain[sea_pkg::NumCells].valid) && $stable(chain[0].valid))
    else $error("divider chain moved while stalled");

  // 8-bit destinations keep the upper result bits clear.
  a_narrow_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !dst_q[2] && !dst_q[1] |-> out_o.result_bits[31:8] == 24'd0)
    else $error("8-bit result has upper bits set");

endmodule

// ===== rtl/sea_front.sv =====
// Operand decode, add, subtract and multiply, feeding the head of the divider chain.
module sea_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         left_i,
  input  logic [31:0]         right_i,
  input  sea_pkg::op_e        op_i,
  input  sea_pkg::type_code_t src_i,
  output sea_pkg::cell_data_t data_o
);

  logic [5:0]         w;
  logic               sgn;
  logic [31:0]        mask;
  logic [31:0]        va, vb;
  logic signed [32:0] a, b;
  logic signed [33:0] res;
  logic               na, nb;
  logic [31:0]        ma, mb;
  sea_pkg::cell_data_t d, q;

  always_comb begin
    w    = sea_pkg::type_width(src_i);
    sgn  = sea_pkg::type_signed(src_i);
    mask = (w == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w[4:0]) - 32'd1);
    va   = left_i & mask;
    vb   = right_i & mask;
    a    = {1'b0, va};
    b    = {1'b0, vb};
    if (sgn && va[w[4:0] - 5'd1]) begin
      a = $signed({1'b0, va}) - $signed({1'b0, mask}) - 33'sd1;
    end
    if (sgn && vb[w[4:0] - 5'd1]) begin
      b = $signed({1'b0, vb}) - $signed({1'b0, mask}) - 33'sd1;
    end
    na = a[32];
    nb = b[32];
    ma = na ? 32'(-a) : a[31:0];
    mb = nb ? 32'(-b) : b[31:0];
    res = (op_i == sea_pkg::OP_SUB) ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));

    d.valid  = valid_i;
    d.is_div = 1'b0;
    d.den    = mb;
    d.rem    = '0;
    case (op_i)
      sea_pkg::OP_ADD, sea_pkg::OP_SUB: begin
        d.neg = res[33];
        d.mag = {30'd0, (res[33] ? 34'(-res) : res)};
      end
      sea_pkg::OP_MUL: begin
        d.mag = 64'(ma) * 64'(mb);
        d.neg = na ^ nb;
      end
      default: begin
        // A zero divisor gives zero and skips the chain's subtract steps.
        d.is_div = (mb != 32'd0);
        d.neg    = na ^ nb;
        d.mag    = (mb != 32'd0) ? {32'd0, ma} : 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q <= '0;
    end else if (en_i) begin
      q <= d;
    end
  end

  assign data_o = q;

endmodule

// ===== rtl/sea_div_cell.sv =====
// One restoring-division step cell; other operations pass through unchanged.
module sea_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  sea_pkg::cell_data_t data_i,
  output sea_pkg::cell_data_t data_o
);

  logic [32:0] trial;
  logic [33:0] diff;
  sea_pkg::cell_data_t d, q;

  always_comb begin
    d     = data_i;
    trial = {data_i.rem[31:0], data_i.mag[31]};
    diff  = {1'b0, trial} - {2'b00, data_i.den};
    if (data_i.is_div) begin
      d.mag[31:0] = {data_i.mag[30:0], ~diff[33]};
      d.rem       = diff[33] ? trial : diff[32:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q <= '0;
    end else if (en_i) begin
      q <= d;
    end
  end

  assign data_o = q;

endmodule

// ===== rtl/sea_back.sv =====
// Saturation to the destination type and the output register.
module sea_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  sea_pkg::cell_data_t data_i,
  input  sea_pkg::type_code_t dst_i,
  output logic                valid_o,
  output logic [31:0]         result_o
);

  logic [5:0]  w;
  logic [63:0] mask, half;
  logic [31:0] res_d, res_q;
  logic        valid_q;

  always_comb begin
    w    = sea_pkg::type_width(dst_i);
    mask = (64'd1 << w) - 64'd1;
    half = 64'd1 << (w - 6'd1);
    if (data_i.mag == 64'd0) begin
      res_d = '0;
    end else if (!sea_pkg::type_signed(dst_i)) begin
      res_d = data_i.neg ? 32'd0 : ((data_i.mag > mask) ? mask[31:0] : data_i.mag[31:0]);
    end else if (!data_i.neg) begin
      res_d = (data_i.mag > half - 64'd1) ? 32'(half - 64'd1) : data_i.mag[31:0];
    end else begin
      res_d = 32'((64'd0 - ((data_i.mag > half) ? half : data_i.mag)) & mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= data_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the saturating element-wise arithmetic unit.
`timescale 1ns / 100ps

module tb_top;

  // Element type codes as the configuration registers encode them.
  localparam sea_pkg::type_code_t T_U8  = 3'd0;
  localparam sea_pkg::type_code_t T_S8  = 3'd1;
  localparam sea_pkg::type_code_t T_U16 = 3'd2;
  localparam sea_pkg::type_code_t T_S16 = 3'd3;
  localparam sea_pkg::type_code_t T_U32 = 3'd4;
  localparam sea_pkg::type_code_t T_S32 = 3'd5;
  localparam sea_pkg::type_code_t T_X6  = 3'd6;
  localparam sea_pkg::type_code_t T_X7  = 3'd7;
  // The spare register index; writes to it must have no effect.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int unsigned NumPhases = 30;
  localparam int unsigned PhaseItems = 55;
  localparam int unsigned DrainCycles = 45;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } operand_pair_t;

  typedef struct {
    sea_pkg::op_e        op;
    sea_pkg::type_code_t src;
    sea_pkg::type_code_t dst;
    logic [31:0]         left;
    logic [31:0]         right;
  } directed_case_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sea_cfg_if cfg_ch ();
  sea_in_if  in_ch ();
  sea_out_if out_ch ();

  saturating_elementwise_alu_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // The testbench's own copy of the configuration registers.
  sea_pkg::op_e        model_op  = sea_pkg::OP_ADD;
  sea_pkg::type_code_t model_src = T_U8;
  sea_pkg::type_code_t model_dst = T_U8;

  operand_pair_t pending_pairs[$];
  logic [31:0]   expected_results[$];
  operand_pair_t next_pair;
  logic          in_taken = 1'b0;
  int unsigned   send_idle = 25;
  int unsigned   recv_idle = 57;
  bit            hold_request = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   failures = 0;

  // Interpret the low bits of a raw element according to its type. Codes six
  // and seven behave as signed 32-bit.
  function automatic longint element_value(input logic [31:0] bits,
                                           input sea_pkg::type_code_t t);
    case (t)
      T_U8:    return longint'(bits[7:0]);
      T_S8:    return longint'($signed(bits[7:0]));
      T_U16:   return longint'(bits[15:0]);
      T_S16:   return longint'($signed(bits[15:0]));
      T_U32:   return longint'(bits);
      default: return longint'($signed(bits));
    endcase
  endfunction

  // Clamp a sign and magnitude pair into the destination range and return raw bits.
  function automatic logic [31:0] saturate(input logic neg, input logic [63:0] mag,
                                           input sea_pkg::type_code_t t);
    int unsigned w;
    logic        sgn;
    logic [63:0] mask;
    logic [63:0] lim;
    w = (t == T_U8 || t == T_S8) ? 8 : (t == T_U16 || t == T_S16) ? 16 : 32;
    sgn = (t == T_S8 || t == T_S16 || t >= T_S32);
    mask = (64'd1 << w) - 64'd1;
    if (mag == 64'd0) begin
      return 32'd0;
    end
    if (!sgn) begin
      if (neg) begin
        return 32'd0;
      end
      return (mag > mask) ? mask[31:0] : mag[31:0];
    end
    if (!neg) begin
      lim = (64'd1 << (w - 1)) - 64'd1;
      return (mag > lim) ? lim[31:0] : mag[31:0];
    end
    lim = 64'd1 << (w - 1);
    if (mag > lim) begin
      mag = lim;
    end
    lim = (64'd0 - mag) & mask;
    return lim[31:0];
  endfunction

  // Exact arithmetic in 64 bits, then saturation to the destination type.
  function automatic logic [31:0] saturated_result(input operand_pair_t p);
    longint      a;
    longint      b;
    longint      x;
    logic [63:0] ma;
    logic [63:0] mb;
    logic        neg;
    logic [63:0] mag;
    a = element_value(p.left, model_src);
    b = element_value(p.right, model_src);
    x = 0;
    case (model_op)
      sea_pkg::OP_ADD: x = a + b;
      sea_pkg::OP_SUB: x = a - b;
      sea_pkg::OP_DIV: x = (b == 0) ? 0 : a / b;
      default: x = 0;
    endcase
    if (model_op == sea_pkg::OP_MUL) begin
      ma = (a < 0) ? 64'(-a) : 64'(a);
      mb = (b < 0) ? 64'(-b) : 64'(b);
      mag = ma * mb;
      neg = ((a < 0) != (b < 0)) && (mag != 64'd0);
    end else begin
      neg = x < 0;
      mag = neg ? 64'(-x) : 64'(x);
    end
    return saturate(neg, mag, model_dst);
  endfunction

  // Operands are biased towards the boundaries where saturation and sign
  // handling matter, with plenty of fully random words as well.
  function automatic logic [31:0] random_operand();
    logic [31:0] edges[10];
    edges = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h80, 32'h7F,
              32'hFF, 32'h8000, 32'h7FFF, 32'hFFFF};
    case ($urandom_range(0, 5))
      0:       return 32'($signed($urandom_range(0, 8)) - 4);
      1:       return edges[$urandom_range(0, 9)];
      2:       return ($urandom() << 8) | 32'($urandom_range(0, 255));
      3:       return 32'($urandom_range(0, 65535)) | ($urandom() & 32'hFFFF_0000);
      default: return $urandom();
    endcase
  endfunction

  // Input driver: a new transaction is presented at the falling edge once the
  // previous one has been taken, unless the sender chooses to idle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_taken) begin
        if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          next_pair = pending_pairs.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.left_bits  <= next_pair.left;
          in_ch.right_bits <= next_pair.right;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so that
  // the pipeline fills and the input stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        hold_left <= 300;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Monitors: every accepted input is predicted with the configuration in
  // force, and every accepted output is checked against the oldest prediction.
  always @(posedge clk_i) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(saturated_result({in_ch.left_bits, in_ch.right_bits}));
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result_bits: unexpected transaction, actual %h", out_ch.result_bits);
        failures++;
      end else if (out_ch.result_bits !== expected_results[0]) begin
        $error("result_bits: expected %h, actual %h", expected_results[0],
               out_ch.result_bits);
        failures++;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // One register write; the model copy is updated when the write is accepted.
  task automatic write_register(input logic [1:0] index, input logic [31:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (index)
      sea_pkg::REG_OPERATION: model_op = sea_pkg::op_e'(data[1:0]);
      sea_pkg::REG_SOURCE:    model_src = data[2:0];
      sea_pkg::REG_DEST:      model_dst = data[2:0];
      default:                ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Upper data bits are random so that the register masking is exercised.
  task automatic configure(input sea_pkg::op_e op, input sea_pkg::type_code_t src,
                           input sea_pkg::type_code_t dst);
    write_register(sea_pkg::REG_OPERATION, ($urandom() << 2) | 32'(op));
    write_register(sea_pkg::REG_SOURCE, ($urandom() << 3) | 32'(src));
    write_register(sea_pkg::REG_DEST, ($urandom() << 3) | 32'(dst));
  endtask

  // Wait until every transaction has been sent and answered, then let the
  // pipeline settle before any register is touched.
  task automatic wait_until_idle();
    wait (pending_pairs.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    directed_case_t directed[14];
    cfg_ch.valid = 1'b0;
    cfg_ch.index = sea_pkg::REG_OPERATION;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_bits = '0;
    in_ch.right_bits = '0;
    out_ch.ready = 1'b0;

    // Saturation at both ends, high bits above the source width, a zero
    // divisor, the most negative s32 over minus one and the spare type codes.
    directed = '{
      '{sea_pkg::OP_ADD, T_U8,  T_U8,  32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{sea_pkg::OP_ADD, T_S8,  T_S8,  32'h0000_0080, 32'h0000_0080},
      '{sea_pkg::OP_SUB, T_U8,  T_U8,  32'h0000_0000, 32'h0000_0001},
      '{sea_pkg::OP_SUB, T_S16, T_U16, 32'h0000_7FFF, 32'h0000_8000},
      '{sea_pkg::OP_SUB, T_S32, T_S32, 32'h8000_0000, 32'h7FFF_FFFF},
      '{sea_pkg::OP_MUL, T_U32, T_U32, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{sea_pkg::OP_MUL, T_S32, T_S32, 32'h8000_0000, 32'h8000_0000},
      '{sea_pkg::OP_MUL, T_S8,  T_S32, 32'hFFFF_FF80, 32'h0000_007F},
      '{sea_pkg::OP_MUL, T_S16, T_S8,  32'h0000_0000, 32'h0000_8000},
      '{sea_pkg::OP_DIV, T_S32, T_S32, 32'h8000_0000, 32'hFFFF_FFFF},
      '{sea_pkg::OP_DIV, T_S32, T_S32, 32'h1234_5678, 32'h0000_0000},
      '{sea_pkg::OP_DIV, T_S8,  T_S8,  32'h0000_00F9, 32'h0000_0002},
      '{sea_pkg::OP_DIV, T_X6,  T_X7,  32'h8000_0000, 32'hFFFF_FFFF},
      '{sea_pkg::OP_ADD, T_X7,  T_X6,  32'h7FFF_FFFF, 32'h0000_0001}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The spare index must leave all three registers untouched.
    write_register(REG_SPARE, $urandom());
    foreach (directed[i]) begin
      configure(directed[i].op, directed[i].src, directed[i].dst);
      pending_pairs.push_back({directed[i].left, directed[i].right});
      wait_until_idle();
    end

    // Random phases. The idle pattern changes every ten phases; each phase is
    // drained before the next configuration, so the sender also pauses until
    // all results are back.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) begin
        configure(sea_pkg::OP_ADD, T_U8, T_U8);
      end else if (phase == NumPhases - 1) begin
        configure(sea_pkg::OP_DIV, T_X7, T_X7);
      end else begin
        configure(sea_pkg::op_e'($urandom_range(0, 3)),
                  sea_pkg::type_code_t'($urandom_range(0, 7)),
                  sea_pkg::type_code_t'($urandom_range(0, 7)));
      end
      if (phase == 10) begin
        send_idle = 57;
        recv_idle = 25;
      end else if (phase == 20) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (phase == 5 || phase == 22) begin
        hold_request = 1'b1;
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        pending_pairs.push_back({random_operand(), random_operand()});
      end
      wait_until_idle();
    end

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
